// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a implies c in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// a implies c in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

// ===== hw/rtl/lru_pkg.sv =====
// ---------------------------------------------------------------------------
// lru_pkg
// Constants for the LRU page replacement unit.
// ---------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAMES_DEF      = 8;
    localparam int PAGE_BITS_DEF   = 16;
    localparam int CFG_W           = 4;
    localparam int FIDX_OUT_W      = 3;
    localparam int CNT_W           = 32;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

endpackage

// ===== hw/rtl/lru_page_replacement_unit.sv =====
// From the input handshake to the earliest result handshake an item passes
//   the input register, then the result register; output backpressure can hold
//   it between the two. One item per cycle sustained, set by the single tag
//   compare and rank update stage, stalled only by output backpressure.
// Reset: synchronous, active low; all frames empty, counters zero,
//   frames_in_use = 8. A frames_in_use write empties every frame.
// ---------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative page-frame table with least-recently-used replacement
// and saturating hit and fault counters.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_page_replacement_unit #(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]       i_cfg_wdata,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [PAGE_BITS-1:0]            i_page_number,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic [lru_pkg::FIDX_OUT_W-1:0]  o_frame_index,
    output logic                            o_evicted_valid,
    output logic [PAGE_BITS-1:0]            o_evicted_page,
    output logic [lru_pkg::CNT_W-1:0]       o_hit_total,
    output logic [lru_pkg::CNT_W-1:0]       o_fault_total
);

    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = FIDX_W;

    // configuration and table state
    logic [lru_pkg::CFG_W-1:0]   r_frames_in_use;
    logic [FRAMES-1:0]           r_frame_valid;
    logic [FRAMES-1:0]           n_frame_valid;
    logic [PAGE_BITS-1:0]        r_frame_page [FRAMES];
    logic [RANK_W-1:0]           r_rank [FRAMES];
    logic [RANK_W-1:0]           n_rank [FRAMES];
    logic [lru_pkg::CNT_W-1:0]   r_hits;
    logic [lru_pkg::CNT_W-1:0]   n_hits;
    logic [lru_pkg::CNT_W-1:0]   r_faults;
    logic [lru_pkg::CNT_W-1:0]   n_faults;

    // input register
    logic                        r_in_valid;
    logic [PAGE_BITS-1:0]        r_in_page;

    // result register
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [lru_pkg::FIDX_OUT_W-1:0] r_out_frame_index;
    logic                        r_out_evicted_valid;
    logic [PAGE_BITS-1:0]        r_out_evicted_page;

    logic                        advance;
    logic [FRAMES-1:0]           active;
    logic [FRAMES-1:0]           hit_vec;
    logic [FRAMES-1:0]           empty_vec;
    logic [FRAMES-1:0]           victim_vec;
    logic [RANK_W-1:0]           last_rank;
    logic                        found;
    logic                        have_empty;
    logic [FIDX_W-1:0]           hit_slot;
    logic [FIDX_W-1:0]           empty_slot;
    logic [FIDX_W-1:0]           victim_slot;
    logic [FIDX_W-1:0]           slot;
    logic [RANK_W-1:0]           old_rank;
    logic                        evict;
    logic [31:0]                 slot_ext;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // active frames: 0 .. max(frames_in_use,1)-1, capped at FRAMES
    always_comb begin
        int lim;
        lim = int'(r_frames_in_use);
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > FRAMES) begin
            lim = FRAMES;
        end
        last_rank = RANK_W'(lim - 1);
        for (int i = 0; i < FRAMES; i++) begin
            active[i] = (i < lim);
        end
    end

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            hit_vec[i]    = active[i] && r_frame_valid[i] && (r_frame_page[i] == r_in_page);
            empty_vec[i]  = active[i] && !r_frame_valid[i];
            victim_vec[i] = active[i] && r_frame_valid[i] && (r_rank[i] == last_rank);
        end
    end

    // lowest-numbered set bit of each vector
    always_comb begin
        hit_slot    = '0;
        empty_slot  = '0;
        victim_slot = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_slot = FIDX_W'(i);
            end
            if (empty_vec[i]) begin
                empty_slot = FIDX_W'(i);
            end
            if (victim_vec[i]) begin
                victim_slot = FIDX_W'(i);
            end
        end
    end

    assign found      = |hit_vec;
    assign have_empty = |empty_vec;
    assign evict      = !found && !have_empty;

    always_comb begin
        priority if (found) begin
            slot = hit_slot;
        end else if (have_empty) begin
            slot = empty_slot;
        end else begin
            slot = victim_slot;
        end
    end

    assign old_rank = r_rank[slot];
    assign slot_ext = 32'(slot);

    // rank update: on a fill every valid frame ages, else those younger than the slot
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            n_rank[i] = r_rank[i];
            if (FIDX_W'(i) == slot) begin
                n_rank[i] = '0;
            end else if (r_frame_valid[i] && active[i]
                         && ((!found && have_empty) || (r_rank[i] < old_rank))) begin
                n_rank[i] = r_rank[i] + RANK_W'(1);
            end
        end
        n_frame_valid = r_frame_valid;
        n_frame_valid[slot] = 1'b1;
        n_hits   = r_hits;
        n_faults = r_faults;
        if (found) begin
            if (r_hits != '1) begin
                n_hits = r_hits + lru_pkg::CNT_W'(1);
            end
        end else begin
            if (r_faults != '1) begin
                n_faults = r_faults + lru_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lru_pkg::FRAMES_IN_USE_RST;
            r_frame_valid   <= '0;
            r_hits          <= '0;
            r_faults        <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // a configuration write wins over a table update
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
                r_frame_valid   <= '0;
                for (int i = 0; i < FRAMES; i++) begin
                    r_rank[i] <= '0;
                end
            end else if (advance) begin
                r_frame_valid <= n_frame_valid;
                r_rank        <= n_rank;
            end
            if (advance) begin
                r_hits   <= n_hits;
                r_faults <= n_faults;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_page <= i_page_number;
        end
        if (advance) begin
            if (!i_cfg_we) begin
                r_frame_page[slot] <= r_in_page;
            end
            r_out_hit           <= found;
            r_out_frame_index   <= slot_ext[lru_pkg::FIDX_OUT_W-1:0];
            r_out_evicted_valid <= evict;
            r_out_evicted_page  <= evict ? r_frame_page[slot] : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_frame_index;
    assign o_evicted_valid = r_out_evicted_valid;
    assign o_evicted_page  = r_out_evicted_page;
    assign o_hit_total     = r_hits;
    assign o_fault_total   = r_faults;

    `ASSERT_IMPLIES(a_hit_no_evict, i_clk, i_rst_n,
                    r_out_valid && r_out_hit, !r_out_evicted_valid)
    `ASSERT_IMPLIES(a_evict_page_zero, i_clk, i_rst_n,
                    r_out_valid && !r_out_evicted_valid, r_out_evicted_page == '0)
    `ASSERT_NEXT(a_cfg_empties, i_clk, i_rst_n, i_cfg_we, r_frame_valid == '0)
    `ASSERT_IMPLIES(a_valid_in_active, i_clk, i_rst_n, 1'b1, (r_frame_valid & ~active) == '0)

endmodule
